// ===== design/mcdf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcdf_pkg
// Shared codes for the multi-channel dimmer fade block.
// ----------------------------------------------------------------------------
package mcdf_pkg;
    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_SWITCH = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_ZC     = 3'd4;
    localparam logic [2:0] OP_SCALE  = 3'd5;

    localparam logic [1:0] DRV_CMP = 2'd0;
    localparam logic [1:0] DRV_ON  = 2'd1;
    localparam logic [1:0] DRV_OFF = 2'd2;

    localparam logic [0:0] REG_REPORT_EN = 1'd0;
    localparam logic [0:0] REG_ZC_WINDOW = 1'd1;

    localparam logic [15:0] CMP_OFF = 16'hFFFF;
    localparam logic [7:0]  LVL_ON  = 8'd255;
    localparam logic [15:0] ZC_WINDOW_RST = 16'd1000;
endpackage
`default_nettype wire

// ===== design/multi_channel_dimmer_fade.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_dimmer_fade
// Phase dimmer with per-channel linear fades, watchdog fallback and reports.
// ----------------------------------------------------------------------------
// Set/switch/stop: an interior level takes one pass of the 24-step shared
//   restoring divider; full on, full off and fade starts skip it.
// Tick: no divider pass for an idle channel, at most one per finishing fade and
//   up to two per running fade (fade step, then mapping); output stalls can hold it.
// Zero-cross and fallback entry: one drive transaction per channel.
// Throughput: one input transaction at a time; ready is low while busy.
// Reset: synchronous, active low; clears state and report enable, loads the
//   default window; levels to off, compares to full off, remembered to full on.
module multi_channel_dimmer_fade #(
    parameter int CHANNELS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_opcode,
    input  wire  [3:0]  i_channel,
    input  wire  [7:0]  i_level,
    input  wire  [15:0] i_duration,
    input  wire         i_candle,
    input  wire         i_turn_on,
    input  wire  [15:0] i_scale_low,
    input  wire  [15:0] i_scale_high,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_kind,
    output logic [3:0]  o_out_channel,
    output logic [1:0]  o_drive,
    output logic [15:0] o_compare,
    output logic [7:0]  o_report_level,
    output logic        o_report_candle,
    output logic        o_last
);
    import mcdf_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CW:0] NCH = (CW+1)'(CHANNELS);

    typedef enum logic [3:0] {
        S_IDLE, S_SET, S_MAP, S_DIV, S_MAPDONE, S_TICK, S_CHAN, S_FADEDIV,
        S_REPORT, S_EMIT, S_WAIT, S_ZC
    } t_state;

    t_state r_state;
    // Return targets for the shared level mapper.
    typedef enum logic [1:0] {R_SET, R_TICK, R_FALL} t_ret;
    t_ret r_ret;

    logic        r_report_en;
    logic [15:0] r_window;

    logic [7:0]  r_cur   [CHANNELS];
    logic [7:0]  r_tgt   [CHANNELS];
    logic [7:0]  r_start [CHANNELS];
    logic [7:0]  r_rem   [CHANNELS];
    logic [15:0] r_len   [CHANNELS];
    logic [15:0] r_elap  [CHANNELS];
    logic [15:0] r_cmp   [CHANNELS];
    logic        r_cdl   [CHANNELS];
    logic [15:0] r_slo   [CHANNELS];
    logic [15:0] r_shi   [CHANNELS];

    logic        r_fallback;
    logic [15:0] r_wticks;
    logic [15:0] r_pulses;
    logic [CW-1:0] r_rptr;
    logic        r_entered;

    // Captured transaction
    logic [2:0]  r_op;
    logic [CW-1:0] r_ch;
    logic [7:0]  r_lv;
    logic [15:0] r_dur;
    logic        r_cd;

    // Shared restoring divider: r_num / r_den, magnitudes, sign applied later.
    logic [23:0] r_num;
    logic [16:0] r_den;
    logic [16:0] r_rem_d;
    logic [4:0]  r_cnt;
    logic        r_neg;
    logic        r_fdiv;    // divider busy with a fade step, not a mapping
    logic [7:0]  r_mlv;     // level being mapped
    logic [15:0] r_base;    // added after division

    logic [17:0] w_trial;
    assign w_trial = {r_rem_d, r_num[23]} - {1'b0, r_den};

    // Output register
    logic        r_ovalid;
    logic        r_okind;
    logic [3:0]  r_och;
    logic [15:0] r_ocmp;
    logic [7:0]  r_olvl;
    logic        r_ocdl;
    logic        r_olast;

    assign o_valid = r_ovalid;
    assign o_kind = r_okind;
    assign o_out_channel = r_och;
    assign o_compare = r_ocmp;
    assign o_drive = (r_okind) ? DRV_CMP :
                     (r_ocmp == 16'd0) ? DRV_ON :
                     (r_ocmp == CMP_OFF) ? DRV_OFF : DRV_CMP;
    assign o_report_level = r_olvl;
    assign o_report_candle = r_ocdl;
    assign o_last = r_olast;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    logic w_last_ch;
    assign w_last_ch = ({1'b0, r_ch} == NCH - 1'b1);

    // Output register gets a new transaction this cycle
    logic w_oload;
    assign w_oload = ((r_state == S_MAPDONE) &&
                      ((r_ret == R_SET && r_fallback) || r_ret == R_FALL)) ||
                     ((r_state == S_REPORT) && r_report_en && (r_len[r_rptr] == 16'd1)) ||
                     ((r_state == S_ZC) && (!r_ovalid || i_ready));

    // Mapping product/difference helpers
    logic signed [16:0] w_diff;
    logic [16:0] w_dmag;
    logic [15:0] w_q;
    logic [15:0] w_sumv;
    logic signed [8:0] w_fd;
    logic [7:0]  w_fmag;
    assign w_diff = $signed({1'b0, r_shi[r_ch]}) - $signed({1'b0, r_slo[r_ch]});
    assign w_dmag = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);
    assign w_q = r_num[15:0];
    assign w_sumv = r_neg ? (r_base - w_q) : (r_base + w_q);
    assign w_fd = $signed({1'b0, r_tgt[r_ch]}) - $signed({1'b0, r_start[r_ch]});
    assign w_fmag = w_fd[8] ? 8'(-w_fd) : 8'(w_fd);

    logic [23:0] w_prod;
    assign w_prod = 24'(w_dmag) * 24'(r_mlv - 8'd1);
    logic [23:0] w_fprod;
    assign w_fprod = 24'(r_elap[r_ch]) * 24'(w_fmag);

    logic [15:0] w_wnext;
    logic [15:0] w_weff;
    assign w_wnext = r_wticks + 16'd1;
    assign w_weff = (r_window == 16'd0) ? 16'd1 : r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= R_SET;
            r_report_en <= 1'b0;
            r_window <= ZC_WINDOW_RST;
            r_fallback <= 1'b0;
            r_wticks <= '0;
            r_pulses <= '0;
            r_rptr <= '0;
            r_entered <= 1'b0;
            r_fdiv <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cur[i] <= '0; r_tgt[i] <= '0; r_start[i] <= '0;
                r_rem[i] <= LVL_ON; r_len[i] <= '0; r_elap[i] <= '0;
                r_cmp[i] <= CMP_OFF; r_cdl[i] <= 1'b0;
                r_slo[i] <= '0; r_shi[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_REPORT_EN: r_report_en <= i_cfg_data[0];
                    REG_ZC_WINDOW: r_window <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready && !w_oload) r_ovalid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op <= i_opcode;
                        r_ch <= (i_opcode == OP_ZC) ? '0 : CW'(i_channel);
                        r_dur <= (i_opcode == OP_STOP) ? '0 : i_duration;
                        r_cd <= (i_opcode == OP_STOP) ? r_cdl[CW'(i_channel)] : i_candle;
                        if ((i_opcode <= OP_STOP || i_opcode == OP_SCALE)
                            && ({1'b0, i_channel} >= 5'(CHANNELS))) begin
                            r_state <= S_IDLE;
                        end else begin
                            case (i_opcode)
                                OP_SET: begin
                                    r_lv <= i_level; r_state <= S_SET;
                                end
                                OP_SWITCH: begin
                                    r_lv <= i_turn_on ? r_rem[CW'(i_channel)] : 8'd0;
                                    r_state <= S_SET;
                                end
                                OP_STOP: begin
                                    r_lv <= r_cur[CW'(i_channel)];
                                    r_state <= S_SET;
                                end
                                OP_SCALE: begin
                                    r_slo[CW'(i_channel)] <= i_scale_low;
                                    r_shi[CW'(i_channel)] <= i_scale_high;
                                end
                                OP_ZC: begin
                                    if (r_pulses != 16'hFFFF) r_pulses <= r_pulses + 16'd1;
                                    r_state <= S_ZC;
                                end
                                OP_TICK: r_state <= S_TICK;
                                default: ;
                            endcase
                        end
                    end
                end
                S_SET: begin
                    // immediate level: mapping via the shared unit, then commit; else start a fade
                    r_cdl[r_ch] <= r_cd;
                    r_tgt[r_ch] <= r_lv;
                    if (r_lv != 8'd0) r_rem[r_ch] <= r_lv;
                    if (r_fallback || r_dur <= 16'd1) begin
                        r_len[r_ch] <= 16'd1;
                        r_mlv <= r_fallback ? ((r_lv != 0) ? LVL_ON : 8'd0) : r_lv;
                        // fallback entry chain returns into R_FALL
                        r_ret <= (r_entered && r_op == OP_TICK) ? R_FALL : R_SET;
                        r_state <= S_MAP;
                    end else begin
                        r_len[r_ch] <= r_dur;
                        r_elap[r_ch] <= '0;
                        r_start[r_ch] <= r_cur[r_ch];
                        r_state <= S_IDLE;
                    end
                end
                S_MAP: begin
                    r_cur[r_ch] <= r_mlv;
                    if (r_mlv == LVL_ON) begin
                        r_cmp[r_ch] <= 16'd0; r_state <= S_MAPDONE;
                    end else if (r_mlv == 8'd0) begin
                        r_cmp[r_ch] <= CMP_OFF; r_state <= S_MAPDONE;
                    end else begin
                        r_num <= w_prod;
                        r_den <= 17'd253;
                        r_rem_d <= '0;
                        r_cnt <= 5'd24;
                        r_neg <= w_diff[16];
                        r_base <= r_slo[r_ch];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 5'd0) begin
                        if (r_fdiv) begin
                            r_mlv <= 8'(w_sumv);
                            r_fdiv <= 1'b0;
                            r_state <= S_MAP;
                        end else begin
                            r_cmp[r_ch] <= w_sumv;
                            r_state <= S_MAPDONE;
                        end
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                        if (!w_trial[17]) begin
                            r_rem_d <= w_trial[16:0];
                            r_num <= {r_num[22:0], 1'b1};
                        end else begin
                            r_rem_d <= {r_rem_d[15:0], r_num[23]};
                            r_num <= {r_num[22:0], 1'b0};
                        end
                    end
                end
                S_MAPDONE: begin
                    case (r_ret)
                        R_SET: begin
                            if (r_fallback) begin
                                r_ovalid <= 1'b1; r_okind <= 1'b0;
                                r_och <= 4'(r_ch); r_ocmp <= r_cmp[r_ch];
                                r_olvl <= '0; r_ocdl <= 1'b0; r_olast <= 1'b1;
                                r_state <= S_WAIT;
                            end else r_state <= S_IDLE;
                        end
                        R_FALL: begin
                            // last channel closes the burst; no fade step or report
                            r_ovalid <= 1'b1; r_okind <= 1'b0;
                            r_och <= 4'(r_ch); r_ocmp <= r_cmp[r_ch];
                            r_olvl <= '0; r_ocdl <= 1'b0; r_olast <= w_last_ch;
                            r_state <= w_last_ch ? S_WAIT : S_EMIT;
                        end
                        default: begin
                            if (w_last_ch) r_state <= S_REPORT;
                            else begin
                                r_ch <= r_ch + 1'b1; r_state <= S_CHAN;
                            end
                        end
                    endcase
                end
                S_EMIT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ch <= r_ch + 1'b1;
                        r_lv <= r_tgt[r_ch + 1'b1];
                        r_cd <= r_cdl[r_ch + 1'b1];
                        r_state <= S_SET;
                    end
                end
                S_TICK: begin
                    r_ch <= '0;
                    if (!r_fallback && w_wnext >= w_weff && r_pulses == 16'd0) begin
                        r_wticks <= '0;
                        r_fallback <= 1'b1;
                        r_entered <= 1'b1;
                        r_lv <= r_tgt[0];
                        r_cd <= r_cdl[0];
                        r_dur <= '0;
                        r_state <= S_SET;
                    end else begin
                        r_entered <= 1'b0;
                        r_state <= S_CHAN;
                        if (!r_fallback) begin
                            if (w_wnext >= w_weff) begin
                                r_wticks <= '0;
                                r_pulses <= '0;
                            end else r_wticks <= w_wnext;
                        end
                    end
                end
                S_CHAN: begin
                    if (r_len[r_ch] <= 16'd1) begin
                        if (w_last_ch) r_state <= S_REPORT;
                        else r_ch <= r_ch + 1'b1;
                    end else begin
                        logic [15:0] e;
                        e = (r_elap[r_ch] != 16'hFFFF) ? r_elap[r_ch] + 16'd1 : r_elap[r_ch];
                        r_elap[r_ch] <= e;
                        r_ret <= R_TICK;
                        if (e < r_len[r_ch]) begin
                            r_state <= S_FADEDIV;
                        end else begin
                            r_len[r_ch] <= 16'd1;
                            r_mlv <= r_tgt[r_ch];
                            r_state <= S_MAP;
                        end
                    end
                end
                S_FADEDIV: begin
                    r_num <= w_fprod;
                    r_den <= {1'b0, r_len[r_ch]};
                    r_rem_d <= '0;
                    r_cnt <= 5'd24;
                    r_neg <= w_fd[8];
                    r_base <= {8'd0, r_start[r_ch]};
                    r_fdiv <= 1'b1;
                    r_state <= S_DIV;
                end
                S_REPORT: begin
                    if (r_report_en) begin
                        r_rptr <= ({1'b0, r_rptr} == NCH - 1'b1) ? '0 : r_rptr + 1'b1;
                        if (r_len[r_rptr] == 16'd1) begin
                            r_len[r_rptr] <= '0;
                            r_ovalid <= 1'b1; r_okind <= 1'b1;
                            r_och <= 4'(r_rptr); r_ocmp <= '0;
                            r_olvl <= r_tgt[r_rptr]; r_ocdl <= r_cdl[r_rptr];
                            r_olast <= 1'b1;
                            r_state <= S_WAIT;
                        end else r_state <= S_IDLE;
                    end else r_state <= S_IDLE;
                end
                S_WAIT: begin
                    if (!r_ovalid || i_ready) r_state <= S_IDLE;
                end
                S_ZC: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1; r_okind <= 1'b0;
                        r_och <= 4'(r_ch); r_ocmp <= r_cmp[r_ch];
                        r_olvl <= '0; r_ocdl <= 1'b0; r_olast <= w_last_ch;
                        if (w_last_ch) r_state <= S_WAIT;
                        else r_ch <= r_ch + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_channel_dimmer_fade: a transaction-level predictor
// of levels, fades, watchdog fallback and completion reports runs next to the
// block. Each received transaction is checked field by field against it.
// ----------------------------------------------------------------------------
module testbench;
    import mcdf_pkg::*;

    localparam int          NCH        = 16;
    localparam int          SETTLE     = 1000;    // outlasts the longest tick
    localparam int          LIMIT      = 1000000;
    localparam logic [2:0]  OP_BAD_A   = 3'd6;    // undefined opcodes
    localparam logic [2:0]  OP_BAD_B   = 3'd7;
    localparam logic        KIND_DRIVE = 1'b0;
    localparam logic        KIND_RPT   = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  ch;
        logic [7:0]  lvl;
        logic [15:0] dur;
        logic        cdl;
        logic        on;
        logic [15:0] slo;
        logic [15:0] shi;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    typedef struct packed {
        logic        kind;
        logic [3:0]  ch;
        logic [1:0]  drive;
        logic [15:0] cmp;
        logic [7:0]  lvl;
        logic        cdl;
        logic        last;
    } dim_out_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [0:0]  i_cfg_index  = '0;
    logic [15:0] i_cfg_data   = '0;
    logic        i_valid      = 1'b0;
    logic [2:0]  i_opcode     = '0;
    logic [3:0]  i_channel    = '0;
    logic [7:0]  i_level      = '0;
    logic [15:0] i_duration   = '0;
    logic        i_candle     = 1'b0;
    logic        i_turn_on    = 1'b0;
    logic [15:0] i_scale_low  = '0;
    logic [15:0] i_scale_high = '0;
    logic        i_ready      = 1'b0;
    logic        o_ready, o_valid, o_kind, o_report_candle, o_last;
    logic [3:0]  o_out_channel;
    logic [1:0]  o_drive;
    logic [15:0] o_compare;
    logic [7:0]  o_report_level;

    always #10 i_clk = ~i_clk;

    multi_channel_dimmer_fade #(.CHANNELS(NCH)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_channel(i_channel), .i_level(i_level),
        .i_duration(i_duration), .i_candle(i_candle), .i_turn_on(i_turn_on),
        .i_scale_low(i_scale_low), .i_scale_high(i_scale_high),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_out_channel(o_out_channel), .o_drive(o_drive),
        .o_compare(o_compare), .o_report_level(o_report_level),
        .o_report_candle(o_report_candle), .o_last(o_last)
    );

    // ------------------------------------------------------------------
    // Predictor state: mirrors the block's per-channel dimmer registers
    // ------------------------------------------------------------------
    logic [7:0]  lvl_now  [NCH];
    logic [7:0]  lvl_goal [NCH];
    logic [7:0]  lvl_from [NCH];
    logic [7:0]  lvl_mem  [NCH];
    logic [15:0] fade_len [NCH];   // 0 idle, 1 report pending, >=2 fading
    logic [15:0] fade_cnt [NCH];
    logic [15:0] cmp_val  [NCH];
    logic        cdl_flag [NCH];
    logic [15:0] scl_lo   [NCH];
    logic [15:0] scl_hi   [NCH];
    logic        in_fallback;
    logic [15:0] wd_ticks;
    logic [15:0] zc_pulses;
    logic [3:0]  rpt_ptr;
    logic        cfg_report;
    logic [15:0] cfg_window;

    dim_out_t    pending_q[$];     // predicted transactions not yet seen
    int          errors    = 0;
    int          n_items   = 0;
    int          n_results = 0;
    int          n_reports = 0;
    int          cycles    = 0;
    bit          no_idle   = 0;    // both sides run without gaps when set

    task automatic predictor_reset();
        for (int i = 0; i < NCH; i++) begin
            lvl_now[i] = 0;  lvl_goal[i] = 0;  lvl_from[i] = 0;  lvl_mem[i] = LVL_ON;
            fade_len[i] = 0; fade_cnt[i] = 0;  cmp_val[i] = CMP_OFF;
            cdl_flag[i] = 0; scl_lo[i] = 0;    scl_hi[i] = 0;
        end
        in_fallback = 0;
        wd_ticks    = 0;
        zc_pulses   = 0;
        rpt_ptr     = 0;
        cfg_report  = 0;
        cfg_window  = ZC_WINDOW_RST;
    endtask

    // Level to compare: 255 full on, 0 full off, 1..254 linear over the scale pair.
    task automatic map_level(int ch, logic [7:0] lv);
        int lo, hi, v;
        lo = scl_lo[ch];
        hi = scl_hi[ch];
        if (lv == LVL_ON)
            cmp_val[ch] = 16'd0;
        else if (lv == 8'd0)
            cmp_val[ch] = CMP_OFF;
        else begin
            v = lo + (int'(lv) - 1) * (hi - lo) / 253;   // truncates toward zero
            cmp_val[ch] = v[15:0];
        end
        lvl_now[ch] = lv;
    endtask

    task automatic push_drive(int ch);
        dim_out_t r;
        r       = '0;
        r.kind  = KIND_DRIVE;
        r.ch    = ch[3:0];
        r.cmp   = cmp_val[ch];
        r.drive = (cmp_val[ch] == 16'd0) ? DRV_ON :
                  (cmp_val[ch] == CMP_OFF) ? DRV_OFF : DRV_CMP;
        pending_q.push_back(r);
    endtask

    task automatic start_level(int ch, logic [7:0] lv, logic [15:0] dur, logic cdl);
        cdl_flag[ch] = cdl;
        if (in_fallback) begin
            map_level(ch, (lv != 0) ? LVL_ON : 8'd0);
            lvl_goal[ch] = lv;
            fade_len[ch] = 1;
            push_drive(ch);
        end else if (dur <= 1) begin
            map_level(ch, lv);
            lvl_goal[ch] = lv;
            fade_len[ch] = 1;
        end else begin
            fade_len[ch] = dur;
            fade_cnt[ch] = 0;
            lvl_goal[ch] = lv;
            lvl_from[ch] = lvl_now[ch];
        end
        if (lv != 0)
            lvl_mem[ch] = lv;
    endtask

    // One millisecond tick: watchdog, fade step, round-robin report.
    task automatic tick_step();
        bit entered;
        int d, v, p;
        entered = 0;
        if (!in_fallback) begin
            wd_ticks++;
            if (wd_ticks >= cfg_window) begin
                wd_ticks = 0;
                if (zc_pulses != 0)
                    zc_pulses = 0;
                else begin
                    in_fallback = 1;
                    entered     = 1;
                    for (int i = 0; i < NCH; i++)
                        start_level(i, lvl_goal[i], 16'd0, cdl_flag[i]);
                end
            end
        end
        for (int i = 0; i < NCH; i++) begin
            if (fade_len[i] > 1) begin
                if (fade_cnt[i] != 16'hFFFF)
                    fade_cnt[i]++;
                if (fade_cnt[i] < fade_len[i]) begin
                    d = int'(lvl_goal[i]) - int'(lvl_from[i]);
                    v = int'(lvl_from[i]) + int'(fade_cnt[i]) * d / int'(fade_len[i]);
                    map_level(i, v[7:0]);
                end else begin
                    map_level(i, lvl_goal[i]);
                    fade_len[i] = 1;
                end
            end
        end
        if (!entered && cfg_report) begin
            p = rpt_ptr;
            if (fade_len[p] == 1) begin
                dim_out_t r;
                r      = '0;
                r.kind = KIND_RPT;
                r.ch   = p[3:0];
                r.lvl  = lvl_goal[p];
                r.cdl  = cdl_flag[p];
                pending_q.push_back(r);
                fade_len[p] = 0;
            end
            rpt_ptr = rpt_ptr + 1'b1;   // wraps at 16 channels
        end
    endtask

    task automatic predict_cmd(cmd_t c);
        int n_before;
        n_before = pending_q.size();
        case (c.op)
            OP_SET:    start_level(c.ch, c.lvl, c.dur, c.cdl);
            OP_SWITCH: start_level(c.ch, c.on ? lvl_mem[c.ch] : 8'd0, c.dur, c.cdl);
            OP_STOP:   start_level(c.ch, lvl_now[c.ch], 16'd0, cdl_flag[c.ch]);
            OP_SCALE: begin
                scl_lo[c.ch] = c.slo;
                scl_hi[c.ch] = c.shi;
            end
            OP_ZC: begin
                for (int i = 0; i < NCH; i++)
                    push_drive(i);
                if (zc_pulses != 16'hFFFF)
                    zc_pulses++;
            end
            OP_TICK:   tick_step();
            default: ;  // undefined opcodes are ignored
        endcase
        if (pending_q.size() > n_before)
            pending_q[$].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Called right after a rising edge; returns at the edge of acceptance.
    task automatic send_cmd(cmd_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_opcode     <= c.op;
        i_channel    <= c.ch;
        i_level      <= c.lvl;
        i_duration   <= c.dur;
        i_candle     <= c.cdl;
        i_turn_on    <= c.on;
        i_scale_low  <= c.slo;
        i_scale_high <= c.shi;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        predict_cmd(c);
        n_items++;
    endtask

    function automatic cmd_t mk(logic [2:0] op, int ch = 0, int lvl = 0, int dur = 0,
                                bit cdl = 0, bit on = 0, int slo = 0, int shi = 0);
        cmd_t c;
        c.op  = op;        c.ch  = ch[3:0];   c.lvl = lvl[7:0];  c.dur = dur[15:0];
        c.cdl = cdl;       c.on  = on;        c.slo = slo[15:0]; c.shi = shi[15:0];
        return c;
    endfunction

    // Random command with random content in every field; fades are mostly short.
    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   pick;
        c      = cmd_t'(CMD_W'({$urandom, $urandom, $urandom}));
        pick   = $urandom_range(0, 99);
        c.op   = (pick < 30) ? OP_SET   : (pick < 42) ? OP_SWITCH :
                 (pick < 48) ? OP_STOP  : (pick < 75) ? OP_TICK   :
                 (pick < 85) ? OP_ZC    : (pick < 96) ? OP_SCALE  :
                 (pick < 98) ? OP_BAD_A : OP_BAD_B;
        if ($urandom_range(0, 7) != 0)
            c.dur = $urandom_range(0, 12);
        case ($urandom_range(0, 5))
            0: c.lvl = 8'd0;
            1: c.lvl = LVL_ON;
            default: ;
        endcase
        return c;
    endfunction

    // Let every expected transaction arrive, then let the block settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_REPORT_EN)
            cfg_report = data[0];
        else
            cfg_window = data;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, compare against the oldest prediction
    // ------------------------------------------------------------------
    int rx_wait = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_ready && o_valid === 1'b1) begin
                dim_out_t got, want;
                got = {o_kind, o_out_channel, o_drive, o_compare, o_report_level,
                       o_report_candle, o_last};
                n_results++;
                if (o_kind === KIND_RPT)
                    n_reports++;
                if (pending_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction, actual %h", $realtime, got);
                end else begin
                    want = pending_q.pop_front();
                    if (got.kind !== want.kind || got.ch !== want.ch ||
                        got.drive !== want.drive || got.cmp !== want.cmp ||
                        got.lvl !== want.lvl || got.cdl !== want.cdl ||
                        got.last !== want.last) begin
                        errors++;
                        $display("%0t: mismatch expected kind=%0d ch=%0d drv=%0d cmp=%0d lvl=%0d cdl=%0d last=%0d",
                                 $realtime, want.kind, want.ch, want.drive, want.cmp,
                                 want.lvl, want.cdl, want.last);
                        $display("%0t:          actual   kind=%0d ch=%0d drv=%0d cmp=%0d lvl=%0d cdl=%0d last=%0d",
                                 $realtime, got.kind, got.ch, got.drive, got.cmp,
                                 got.lvl, got.cdl, got.last);
                    end
                end
                rx_wait = no_idle ? 0 : $urandom_range(0, 3);
            end else if (rx_wait > 0)
                rx_wait--;
            i_ready <= (rx_wait == 0);
        end
    end

    // Watchdog on the whole run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Scale extremes, full on/off, interior levels, switch, stop, candle,
    // one-tick fade, reports and ignored opcodes.
    task automatic test_directed();
        write_reg(REG_REPORT_EN, 16'd1);
        write_reg(REG_ZC_WINDOW, 16'hFFFF);
        send_cmd(mk(OP_SCALE, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        send_cmd(mk(OP_SCALE, 15, 0, 0, 0, 0, 16'hFFFF, 0));   // falling slope
        send_cmd(mk(OP_SET, 0, 1));
        send_cmd(mk(OP_SET, 15, 254, 0, 1));
        send_cmd(mk(OP_ZC));
        send_cmd(mk(OP_SET, 0, 128, 1));                       // one-tick fade is immediate
        send_cmd(mk(OP_SET, 15, LVL_ON));
        send_cmd(mk(OP_SET, 1, 200, 4, 1));
        send_cmd(mk(OP_TICK));
        send_cmd(mk(OP_TICK));
        send_cmd(mk(OP_STOP, 1));                              // stop mid fade
        send_cmd(mk(OP_SWITCH, 0, 0, 0, 0, 0));                // off
        send_cmd(mk(OP_SWITCH, 0, 0, 3, 1, 1));                // back to remembered level
        send_cmd(mk(OP_SET, 7, 0, 16'hFFFF));                  // long fade
        send_cmd(mk(OP_ZC));
        repeat (4) send_cmd(mk(OP_TICK));
        send_cmd(mk(OP_BAD_A, 3, 99, 2));
        send_cmd(mk(OP_BAD_B, 3, 99, 2));
        send_cmd(mk(OP_ZC));
        drain();
    endtask

    // Random fades with reports off, then on so the held reports drain.
    task automatic test_random_fades();
        write_reg(REG_REPORT_EN, 16'd0);
        write_reg(REG_ZC_WINDOW, ZC_WINDOW_RST);
        repeat (25) send_cmd(rand_cmd());
        drain();
        write_reg(REG_REPORT_EN, 16'd1);
        repeat (25) send_cmd(rand_cmd());
        drain();
    endtask

    // Back-to-back transactions on both sides.
    task automatic test_no_idle();
        no_idle = 1;
        repeat (15) send_cmd(rand_cmd());
        drain();
        no_idle = 0;
    endtask

    // Short watchdog window: one window rescued by a zero-cross, then loss.
    task automatic test_fallback();
        write_reg(REG_ZC_WINDOW, 16'd1);
        send_cmd(mk(OP_ZC));
        send_cmd(mk(OP_TICK));                                 // pulses seen, window restarts
        send_cmd(mk(OP_TICK));                                 // no pulses: fallback
        repeat (20) send_cmd(rand_cmd());
        drain();
    endtask

    initial begin
        predictor_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_fades();
        test_no_idle();
        test_fallback();
        $display("Covered %0d transactions in, %0d out (%0d completion reports),",
                 n_items, n_results, n_reports);
        $display("across fades, scaling, zero-cross drives and the fallback path.");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
